FILE: src/bf5_pkg.sv
// Shared types, constants and elaboration-time tables for the 5x5 bilateral filter.
// No dependencies; imported by every module of the block.
package bf5_pkg;

   localparam int WIN = 5;
   localparam int NTAPS = WIN * WIN;
   localparam int HALF = WIN / 2;
   localparam int MAX_HEIGHT = 4096;
   localparam int QDEPTH = 4;
   localparam int NUM_W = 45;   // 25 * 65535 * 65535 * 255
   localparam int DEN_W = 37;   // 25 * 65535 * 65535
   localparam int REM_W = 46;
   localparam int QB = 9;       // quotient bits
   localparam logic [2:0] CLS_NONE = 3'd6;

   typedef enum logic [2:0] {
      CSR_WIDTH = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_SW_D0 = 3'd2,
      CSR_SW_D1 = 3'd3,
      CSR_SW_D2 = 3'd4,
      CSR_SW_D4 = 3'd5,
      CSR_SW_D5 = 3'd6,
      CSR_SW_D8 = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_OUT
   } back_state_type;

   typedef logic [23:0] pixel_type;

   typedef struct packed {
      pixel_type [NTAPS-1:0] tap;
      logic [11:0] row;
      logic [9:0] col;
   } win_entry_type;

   typedef struct packed {
      logic [5:0][15:0] sw;
   } spatial_cfg_type;

   typedef logic [255:0][15:0] rt_type;
   typedef logic [NTAPS-1:0][2:0] cls_type;

   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [63:0] p;
      p = a * b + 64'h8000_0000;
      return p >> 32;
   endfunction

   // shift-subtract divide, only used while building constants
   function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
      logic [63:0] q;
      logic [64:0] rem;
      q = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic rt_type build_range(int sigma);
      rt_type tab;
      logic [63:0] s, y, term, sum, r, b;
      logic [16:0] e;
      s = (sigma < 1) ? 64'd1 : 64'(sigma);
      y = udiv((64'd1 << 32) + s * s, 64'd2 * s * s);
      term = 64'd1 << 32;
      sum = 64'd1 << 32;
      for (int k = 1; k <= 20; k++) begin
         term = udiv((term * y) >> 32, 64'(k));
         if (k % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      for (int d = 0; d < 256; d++) begin
         r = 64'd1 << 32;
         b = sum;
         e = 17'(d * d);
         for (int i = 0; i < 17; i++) begin
            if (e[i]) r = qmul(r, b);
            b = qmul(b, b);
         end
         r = (r + 64'h8000) >> 16;
         tab[d] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
      end
      return tab;
   endfunction

   // spatial weight class of each tap from its squared distance to the centre
   function automatic cls_type build_cls();
      cls_type c;
      int d2, t;
      t = 0;
      for (int dy = 0; dy < WIN; dy++) begin
         for (int dx = 0; dx < WIN; dx++) begin
            d2 = (dy - HALF) * (dy - HALF) + (dx - HALF) * (dx - HALF);
            unique case (d2)
               0: c[t] = 3'd0;
               1: c[t] = 3'd1;
               2: c[t] = 3'd2;
               4: c[t] = 3'd3;
               5: c[t] = 3'd4;
               8: c[t] = 3'd5;
               default: c[t] = CLS_NONE;
            endcase
            t++;
         end
      end
      return c;
   endfunction

endpackage

FILE: src/bf5_front.sv
// Front end: raster counters, line buffer of the four previous rows and the 5x5 window.
// Depends on bf5_pkg; pushes complete windows into bf5_queue.
module bf5_front import bf5_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,   // chan_red, chan_green, chan_blue
   input  logic req_tuser,          // frame_start
   input  logic [10:0] cfg_width,
   input  logic [12:0] cfg_height,
   input  logic [2:0] q_count,
   output logic q_push,
   output win_entry_type q_data
);
   localparam int AW = $clog2(MAX_WIDTH);

   logic [95:0] mem [MAX_WIDTH];
   logic [95:0] rd_ff;
   logic [AW-1:0] col_ff, cb_ff;
   logic [11:0] row_ff, rb_ff;
   logic vb_ff, emitb_ff;
   pixel_type pixb_ff;
   pixel_type [WIN-1:0][WIN-1:0] wc_ff, wc_in;   // [dx][dy]
   logic acc, emit_a;
   logic [13:0] wid_e, hgt_e, c0, r0, c1, r1;
   logic [95:0] wdata;
   logic [13:0] cb_wide;

   assign req_tready = (4'(q_count) + 4'(vb_ff)) < 4'(QDEPTH);
   assign acc = req_tvalid && req_tready;

   always_comb begin
      wid_e = 14'(cfg_width);
      if (wid_e < 14'(WIN)) wid_e = 14'(WIN);
      if (wid_e > 14'(MAX_WIDTH)) wid_e = 14'(MAX_WIDTH);
      hgt_e = 14'(cfg_height);
      if (hgt_e < 14'(WIN)) hgt_e = 14'(WIN);
      if (hgt_e > 14'(MAX_HEIGHT)) hgt_e = 14'(MAX_HEIGHT);
      c0 = 14'(col_ff);
      r0 = 14'(row_ff);
      if (req_tuser) begin
         c0 = '0;
         r0 = '0;
      end
      if (c0 >= wid_e) begin
         c0 = '0;
         r0 = r0 + 14'd1;
      end
      if (r0 >= hgt_e) r0 = '0;
      emit_a = (r0 >= 14'(WIN - 1)) && (c0 >= 14'(WIN - 1));
      c1 = c0 + 14'd1;
      r1 = r0;
      if (c1 >= wid_e) begin
         c1 = '0;
         r1 = r0 + 14'd1;
         if (r1 >= hgt_e) r1 = '0;
      end
   end

   // column store shifts one row per write: low word is the row just above
   assign wdata = {rd_ff[71:0], pixb_ff};

   always_ff @(posedge clock) begin
      if (acc) begin
         if (vb_ff && cb_ff == c0[AW-1:0]) rd_ff <= wdata;
         else rd_ff <= mem[c0[AW-1:0]];
      end
      if (vb_ff) mem[cb_ff] <= wdata;
   end

   always_comb begin
      for (int dx = 0; dx < WIN - 1; dx++) wc_in[dx] = wc_ff[dx+1];
      wc_in[WIN-1] = {pixb_ff, rd_ff[23:0], rd_ff[47:24], rd_ff[71:48], rd_ff[95:72]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         vb_ff <= acc;
         if (acc) begin
            col_ff <= c1[AW-1:0];
            row_ff <= r1[11:0];
         end
      end
      if (acc) begin
         cb_ff <= c0[AW-1:0];
         rb_ff <= r0[11:0];
         emitb_ff <= emit_a;
         pixb_ff <= req_tdata;
      end
      if (vb_ff) wc_ff <= wc_in;
   end

   assign cb_wide = 14'(cb_ff) - 14'(HALF);
   assign q_push = vb_ff && emitb_ff;

   always_comb begin
      for (int dy = 0; dy < WIN; dy++)
         for (int dx = 0; dx < WIN; dx++)
            q_data.tap[dy*WIN+dx] = wc_in[dx][dy];
      q_data.row = rb_ff - 12'(HALF);
      q_data.col = cb_wide[9:0];
   end
endmodule

FILE: src/bf5_queue.sv
// Short window queue between front and back end.
// Depends on bf5_pkg for the entry type and depth.
module bf5_queue import bf5_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  win_entry_type push_data,
   input  logic pop,
   output win_entry_type head,
   output logic [2:0] count
);
   win_entry_type ents_ff [QDEPTH];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign head = ents_ff[rp_ff];
   assign count = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
      if (push) ents_ff[wp_ff] <= push_data;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 3'(QDEPTH) || pop)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 3'd0) else $error("queue underflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QDEPTH)) else $error("queue count out of range");
`endif
endmodule

FILE: src/bf5_back.sv
// Back end: per-tap weight and accumulate for three channels, then a bit-serial divide.
// Depends on bf5_pkg for the range table, tap classes and window entry.
module bf5_back import bf5_pkg::*; #(
   parameter int RANGE_SIGMA = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic [2:0] q_count,
   input  win_entry_type q_head,
   output logic q_pop,
   input  spatial_cfg_type cfg,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [47:0] rsp_tdata
);
   localparam rt_type RT = build_range(RANGE_SIGMA);
   localparam cls_type CLS = build_cls();

   back_state_type state_ff, state_in;
   win_entry_type ent_ff;
   logic [4:0] t_ff;
   logic [3:0] i_ff;
   logic init_ff;
   logic [2:0][31:0] w_ff;
   logic [2:0][7:0] p_ff;
   logic [2:0][NUM_W-1:0] num_ff;
   logic [2:0][DEN_W-1:0] den_ff;
   logic [2:0][REM_W-1:0] rem_ff;
   logic [2:0][QB-1:0] q_ff;
   logic [4:0] tidx;
   pixel_type tap, ctr;
   logic [15:0] sp;
   logic [2:0][7:0] res;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (q_count != 3'd0) state_in = ST_MAC;
         ST_MAC:  if (t_ff == 5'(NTAPS)) state_in = ST_DIV;
         ST_DIV:  if (!init_ff && i_ff == 4'd0) state_in = ST_OUT;
         ST_OUT:  if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop = (state_ff == ST_IDLE) && (q_count != 3'd0);
      rsp_tvalid = (state_ff == ST_OUT);
   end

   assign tidx = (t_ff < 5'(NTAPS)) ? t_ff : '0;
   assign tap = ent_ff.tap[tidx];
   assign ctr = ent_ff.tap[NTAPS/2];
   assign sp = (CLS[tidx] == CLS_NONE) ? 16'd0 : cfg.sw[CLS[tidx]];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      unique case (state_ff)
         ST_IDLE: begin
            ent_ff <= q_head;
            t_ff <= '0;
            num_ff <= '0;
            den_ff <= '0;
         end
         ST_MAC: begin
            for (int ch = 0; ch < 3; ch++) begin
               logic [7:0] p, cv, diff;
               p = tap[ch*8 +: 8];
               cv = ctr[ch*8 +: 8];
               diff = (p > cv) ? p - cv : cv - p;
               if (t_ff != 5'd0) begin
                  num_ff[ch] <= num_ff[ch] + NUM_W'(w_ff[ch]) * NUM_W'(p_ff[ch]);
                  den_ff[ch] <= den_ff[ch] + DEN_W'(w_ff[ch]);
               end
               w_ff[ch] <= sp * RT[diff];
               p_ff[ch] <= p;
            end
            t_ff <= t_ff + 5'd1;
            init_ff <= 1'b1;
         end
         ST_DIV: begin
            if (init_ff) begin
               for (int ch = 0; ch < 3; ch++)
                  rem_ff[ch] <= REM_W'(num_ff[ch]) + REM_W'(den_ff[ch] >> 1);
               i_ff <= 4'(QB - 1);
               init_ff <= 1'b0;
            end else begin
               for (int ch = 0; ch < 3; ch++) begin
                  logic [REM_W-1:0] dsh;
                  dsh = REM_W'(den_ff[ch]) << i_ff;
                  if (rem_ff[ch] >= dsh) begin
                     rem_ff[ch] <= rem_ff[ch] - dsh;
                     q_ff[ch][i_ff] <= 1'b1;
                  end else begin
                     q_ff[ch][i_ff] <= 1'b0;
                  end
               end
               i_ff <= i_ff - 4'd1;
            end
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         if (den_ff[ch] == '0) res[ch] = ctr[ch*8 +: 8];
         else if (q_ff[ch] > 9'd255) res[ch] = 8'hFF;
         else res[ch] = q_ff[ch][7:0];
      end
   end

   assign rsp_tdata = {2'b00, ent_ff.col, ent_ff.row, res[2], res[1], res[0]};

`ifndef SYNTHESIS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_MAC) else $error("pop did not start a window");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_mac_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> t_ff <= 5'(NTAPS)) else $error("tap counter overran");
`endif
endmodule

FILE: src/bilateral_filter_5x5.sv
// Top level of the 5x5 bilateral filter: configuration registers and the three parts.
// Depends on bf5_pkg, bf5_front, bf5_queue and bf5_back.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata r,g,b ; tuser frame_start
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata center_col,center_row,r,g,b
//  csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// A pixel is taken each cycle while the window queue has room; pixels that complete
// a window are filtered by the back end (a tap-accumulate loop over every tap for all
// three channels, a bit-serial divide, result hand-off), so the sustained rate for
// interior pixels is set by that tap loop. Reset is synchronous and clears the counters,
// queue, back-end state and configuration registers; the line buffer and datapath
// registers hold no reset. A stalled result backs up the queue and then req_tready.
module bilateral_filter_5x5 import bf5_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int RANGE_SIGMA = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,   // chan_red, chan_green, chan_blue
   input  logic req_tuser,          // frame_start
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [47:0] rsp_tdata,   // center_col, center_row, out_red, out_green, out_blue
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [7:0] csr_index,
   input  logic [15:0] csr_data
);
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   spatial_cfg_type sw_ff;
   logic q_push, q_pop;
   win_entry_type q_in, q_head;
   logic [2:0] q_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 11'd512;
         height_ff <= 13'd512;
         sw_ff.sw <= {16'd600, 16'd2690, 16'd4435, 16'd12055, 16'd19875, 16'd32768};
      end else if (csr_valid && csr_index[7:3] == 5'd0) begin
         unique case (csr_idx_type'(csr_index[2:0]))
            CSR_WIDTH:  width_ff <= csr_data[10:0];
            CSR_HEIGHT: height_ff <= csr_data[12:0];
            CSR_SW_D0:  sw_ff.sw[0] <= csr_data;
            CSR_SW_D1:  sw_ff.sw[1] <= csr_data;
            CSR_SW_D2:  sw_ff.sw[2] <= csr_data;
            CSR_SW_D4:  sw_ff.sw[3] <= csr_data;
            CSR_SW_D5:  sw_ff.sw[4] <= csr_data;
            CSR_SW_D8:  sw_ff.sw[5] <= csr_data;
            default: ;
         endcase
      end
   end

   bf5_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .cfg_width(width_ff), .cfg_height(height_ff),
      .q_count(q_count), .q_push(q_push), .q_data(q_in)
   );

   bf5_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in), .pop(q_pop),
      .head(q_head), .count(q_count)
   );

   bf5_back #(.RANGE_SIGMA(RANGE_SIGMA)) u_back (
      .clock(clock), .reset(reset),
      .q_count(q_count), .q_head(q_head), .q_pop(q_pop),
      .cfg(sw_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule
